[design/sliding_window_max_pool_top_assert.svh]
// ----------------------------------------------------------------------------
// sliding window max pool assertion macros
// shared property wrappers for the block's checker
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MAX_POOL_TOP_ASSERT_SVH
`define SLIDING_WINDOW_MAX_POOL_TOP_ASSERT_SVH

// property checked only while out of reset
`define SWMP_ASSERT(label, clk_i, rst_ni, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked on every edge, reset included
`define SWMP_ASSERT_NORST(label, clk_i, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[design/swmp_pkg.sv]
// ----------------------------------------------------------------------------
// swmp_pkg
// shared widths, register codes and transaction types of the max pool block
// ----------------------------------------------------------------------------
package swmp_pkg;

  // default sizing of the line memory
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_WINDOW_DEF = 16;

  // field widths
  localparam int unsigned PIX_W     = 32;
  localparam int unsigned ROW_W     = 16;
  localparam int unsigned COL_OUT_W = 10;
  localparam int unsigned SUM_W     = 63;

  // configuration register widths
  localparam int unsigned CFG_WIDTH_W  = 11;
  localparam int unsigned CFG_HEIGHT_W = 16;
  localparam int unsigned CFG_WINDOW_W = 5;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd2;

  // configuration reset values
  localparam logic [CFG_WIDTH_W-1:0]  CFG_WIDTH_RST  = 11'd1024;
  localparam logic [CFG_HEIGHT_W-1:0] CFG_HEIGHT_RST = 16'd1024;
  localparam logic [CFG_WINDOW_W-1:0] CFG_WINDOW_RST = 5'd2;

  // running sum ceiling
  localparam logic [SUM_W-1:0] SUM_LIMIT = {SUM_W{1'b1}};

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             start_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]     window_max;
    logic [ROW_W-1:0]     window_row;
    logic [COL_OUT_W-1:0] window_col;
    logic [SUM_W-1:0]     running_sum;
    logic                 frame_done;
  } out_item_t;

endpackage

[design/swmp_stream_if.sv]
// ----------------------------------------------------------------------------
// swmp_stream_if
// valid/ready channel carrying one transaction payload
// ----------------------------------------------------------------------------
interface swmp_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

[design/sliding_window_max_pool_top.sv]
// ----------------------------------------------------------------------------
// sliding_window_max_pool_top
// stride-1 square max pooling over a raster stream with a running sum
// ----------------------------------------------------------------------------
// Usage:
//   in_stream carries one matrix element per transaction, raster order;
//   start_of_frame forces the element to row 0, column 0. out_stream gives
//   one result per element that closes a full window: the window maximum,
//   its top-left position, the saturating sum of maxima in the frame and a
//   last-window flag. Elements that close no window give no result.
//   cfg_we/cfg_index/cfg_wdata write image_width, image_height and
//   window_size; write them only while the block is idle.
// Sequence (k = effective window size):
//   an element left of column k - 1 needs no work after accept; any other
//   element scans k taps and k - 1 stored rows and writes back; one that
//   closes a window then delivers its result to the output register.
//   The line memory read port returns one stored row maximum per cycle
//   during the vertical scan.
// Reset: position and running sum go to zero, registers to 1024/1024/2;
//   line memory is not cleared, so no clearing pass is needed.
// Stall: a result waits in the output register; the block still accepts and
//   works on the next element and holds in its output step until the
//   register is free.
// ----------------------------------------------------------------------------
module sliding_window_max_pool_top #(
  parameter int unsigned MAX_WIDTH  = swmp_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_WINDOW = swmp_pkg::MAX_WINDOW_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [swmp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swmp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  swmp_stream_if.sink                      in_stream,
  swmp_stream_if.source                    out_stream
);

  import swmp_pkg::*;

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned WEFF_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned KW     = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SLOT_W = $clog2(MAX_WINDOW);
  localparam int unsigned CW     = (WEFF_W > KW) ? WEFF_W : KW;
  localparam int unsigned DEPTH  = MAX_WINDOW * MAX_WIDTH;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam logic [AW-1:0]     ROW_STRIDE = AW'(MAX_WIDTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(MAX_WINDOW - 1);

  // sequencer codes
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_LAST) ? '0 : s + SLOT_W'(1);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
    return (s == '0) ? SLOT_LAST : s - SLOT_W'(1);
  endfunction

  // configuration registers
  logic [CFG_WIDTH_W-1:0]  cfg_width_r;
  logic [CFG_HEIGHT_W-1:0] cfg_height_r;
  logic [CFG_WINDOW_W-1:0] cfg_window_r;

  // effective configuration
  logic [WEFF_W-1:0] w_eff;
  logic [ROW_W-1:0]  h_eff;
  logic [KW-1:0]     k_eff;

  // stored position of the next element
  logic [COL_W-1:0]  col_r,  col_nxt;
  logic [ROW_W-1:0]  row_r,  row_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  // position of the accepted element
  logic [COL_W-1:0]  col_a, col_c;
  logic [ROW_W-1:0]  row_a, row_c;
  logic [ROW_W:0]    row_b, row_inc;
  logic [SLOT_W-1:0] slot_a, slot_b, slot_c;
  logic [WEFF_W-1:0] col_inc;
  logic              do_h, do_v;

  // working registers for the current element
  logic [COL_W-1:0]  cur_c_r,    cur_c_nxt;
  logic [ROW_W-1:0]  cur_r_r,    cur_r_nxt;
  logic [SLOT_W-1:0] cur_slot_r, cur_slot_nxt;
  logic              do_v_r,     do_v_nxt;
  logic [1:0]        state_r,    state_nxt;
  logic [SLOT_W-1:0] cnt_r,      cnt_nxt;
  logic [SLOT_W-1:0] rd_slot_r,  rd_slot_nxt;
  logic              rd_pend_r;
  logic [PIX_W-1:0]  hmax_r,     hmax_nxt;
  logic [PIX_W-1:0]  vmax_r,     vmax_nxt;
  logic [PIX_W-1:0]  vmax_acc;
  logic [SUM_W-1:0]  sum_r,      sum_nxt;
  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  sum_sat;
  logic              cnt_last;
  logic              in_fire;

  // recent pixels of the current row, newest first
  logic [PIX_W-1:0]  taps_r [MAX_WINDOW];
  logic [PIX_W-1:0]  tap_sel;

  // line memory ports
  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [PIX_W-1:0]  rd_data;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic              load_out;
  out_item_t         out_item_r;
  out_item_t         out_item;
  logic [CW-1:0]     col_diff;

  assign in_fire         = in_stream.valid && in_stream.ready;
  assign in_stream.ready = (state_r == ST_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= CFG_WIDTH_RST;
      cfg_height_r <= CFG_HEIGHT_RST;
      cfg_window_r <= CFG_WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  cfg_width_r  <= cfg_wdata[CFG_WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: cfg_height_r <= cfg_wdata[CFG_HEIGHT_W-1:0];
        CFG_WINDOW_SIZE:  cfg_window_r <= cfg_wdata[CFG_WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize width and window clamp to the memory limits
  always_comb begin
    if (cfg_width_r == '0) begin
      w_eff = WEFF_W'(1);
    end else if (32'(cfg_width_r) > MAX_WIDTH) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(cfg_width_r);
    end
    h_eff = (cfg_height_r == '0) ? ROW_W'(1) : cfg_height_r;
    if (cfg_window_r == '0) begin
      k_eff = KW'(1);
    end else if (32'(cfg_window_r) > MAX_WINDOW) begin
      k_eff = KW'(MAX_WINDOW);
    end else begin
      k_eff = KW'(cfg_window_r);
    end
  end

  // position of the accepted element and of the one after it
  always_comb begin
    col_a  = in_stream.data.start_of_frame ? '0 : col_r;
    row_a  = in_stream.data.start_of_frame ? '0 : row_r;
    slot_a = in_stream.data.start_of_frame ? '0 : slot_r;

    // stale column after a width change wraps to the next row
    if (WEFF_W'(col_a) >= w_eff) begin
      col_c  = '0;
      row_b  = {1'b0, row_a} + (ROW_W+1)'(1);
      slot_b = slot_inc(slot_a);
    end else begin
      col_c  = col_a;
      row_b  = {1'b0, row_a};
      slot_b = slot_a;
    end
    if (row_b >= {1'b0, h_eff}) begin
      row_c  = '0;
      slot_c = '0;
    end else begin
      row_c  = row_b[ROW_W-1:0];
      slot_c = slot_b;
    end

    // advance for the next element
    col_inc = WEFF_W'(col_c) + WEFF_W'(1);
    row_inc = {1'b0, row_c} + (ROW_W+1)'(1);
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      if (row_inc >= {1'b0, h_eff}) begin
        row_nxt  = '0;
        slot_nxt = '0;
      end else begin
        row_nxt  = row_inc[ROW_W-1:0];
        slot_nxt = slot_inc(slot_c);
      end
    end else begin
      col_nxt  = col_inc[COL_W-1:0];
      row_nxt  = row_c;
      slot_nxt = slot_c;
    end

    do_h = (CW'(col_c) + CW'(1)) >= CW'(k_eff);
    do_v = row_inc >= (ROW_W+1)'(k_eff);
  end

  // scan helpers
  assign tap_sel  = taps_r[cnt_r];
  assign cnt_last = (KW'(cnt_r) + KW'(1)) == k_eff;
  assign vmax_acc = (rd_pend_r && (rd_data > vmax_r)) ? rd_data : vmax_r;
  assign rd_addr  = AW'(rd_slot_r) * ROW_STRIDE + AW'(cur_c_r);
  assign wr_addr  = AW'(cur_slot_r) * ROW_STRIDE + AW'(cur_c_r);

  // saturating running sum
  assign sum_wide = {1'b0, sum_r} + (SUM_W+1)'(vmax_r);
  assign sum_sat  = sum_wide[SUM_W] ? SUM_LIMIT : sum_wide[SUM_W-1:0];

  // result fields
  assign col_diff = CW'(cur_c_r) + CW'(1) - CW'(k_eff);
  always_comb begin
    out_item.window_max  = vmax_r;
    out_item.window_row  = cur_r_r + ROW_W'(1) - ROW_W'(k_eff);
    out_item.window_col  = COL_OUT_W'(col_diff);
    out_item.running_sum = sum_sat;
    out_item.frame_done  = (({1'b0, cur_r_r} + (ROW_W+1)'(1)) == {1'b0, h_eff}) &&
                           ((WEFF_W'(cur_c_r) + WEFF_W'(1)) == w_eff);
  end

  // sequencer: accept, scan taps and line memory, write back, deliver
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rd_slot_nxt   = rd_slot_r;
    hmax_nxt      = hmax_r;
    vmax_nxt      = vmax_r;
    sum_nxt       = sum_r;
    cur_c_nxt     = cur_c_r;
    cur_r_nxt     = cur_r_r;
    cur_slot_nxt  = cur_slot_r;
    do_v_nxt      = do_v_r;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r && !out_stream.ready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cur_c_nxt    = col_c;
          cur_r_nxt    = row_c;
          cur_slot_nxt = slot_c;
          do_v_nxt     = do_v;
          hmax_nxt     = '0;
          vmax_nxt     = '0;
          cnt_nxt      = '0;
          rd_slot_nxt  = slot_dec(slot_c);
          if (col_c == '0 && row_c == '0) begin
            sum_nxt = '0;
          end
          state_nxt = do_h ? ST_SCAN : ST_IDLE;
        end
      end
      ST_SCAN: begin
        // one tap and one earlier row per cycle
        hmax_nxt = (tap_sel > hmax_r) ? tap_sel : hmax_r;
        vmax_nxt = vmax_acc;
        if (cnt_last) begin
          state_nxt = ST_WRITE;
        end else begin
          rd_en       = 1'b1;
          rd_slot_nxt = slot_dec(rd_slot_r);
          cnt_nxt     = cnt_r + SLOT_W'(1);
        end
      end
      ST_WRITE: begin
        // current row takes its horizontal max straight from the register
        wr_en     = 1'b1;
        vmax_nxt  = (hmax_r > vmax_acc) ? hmax_r : vmax_acc;
        state_nxt = do_v_r ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        if (!out_valid_r || out_stream.ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          sum_nxt       = sum_sat;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      slot_r      <= '0;
      sum_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      rd_pend_r   <= rd_en;
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        slot_r <= slot_nxt;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cur_c_r    <= cur_c_nxt;
    cur_r_r    <= cur_r_nxt;
    cur_slot_r <= cur_slot_nxt;
    do_v_r     <= do_v_nxt;
    cnt_r      <= cnt_nxt;
    rd_slot_r  <= rd_slot_nxt;
    hmax_r     <= hmax_nxt;
    vmax_r     <= vmax_nxt;
    if (load_out) begin
      out_item_r <= out_item;
    end
  end

  // shift line of recent pixels
  always_ff @(posedge clk) begin
    if (in_fire) begin
      taps_r[0] <= in_stream.data.pixel_value;
      for (int i = 1; i < MAX_WINDOW; i++) begin
        taps_r[i] <= taps_r[i-1];
      end
    end
  end

  // line memory of horizontal maxima, one row per slot
  swmp_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (hmax_r),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign out_stream.valid = out_valid_r;
  assign out_stream.data  = out_item_r;

endmodule

[design/swmp_ram.sv]
// ----------------------------------------------------------------------------
// swmp_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module swmp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/swmp_checker.sv]
// ----------------------------------------------------------------------------
// swmp_checker
// port-level checks of the max pool block, bound to the top level
// ----------------------------------------------------------------------------
`include "sliding_window_max_pool_top_assert.svh"

module swmp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input swmp_pkg::out_item_t out_item
);

  import swmp_pkg::*;

  // a stalled result stays offered
  `SWMP_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // a stalled result keeps its payload
  `SWMP_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_item), "result changed while stalled")

  // a new result only follows a cycle in which the block was busy
  `SWMP_ASSERT(a_busy_before_result, clk, rst_n, $rose(out_valid) |-> $past(!in_ready), "result without work")

  // the running sum always covers the maximum just added
  `SWMP_ASSERT(a_sum_covers_max, clk, rst_n, out_valid |-> out_item.running_sum >= SUM_W'(out_item.window_max), "running sum below window max")

  // reset empties the output register
  `SWMP_ASSERT_NORST(a_reset_empties, clk, !rst_n |=> !out_valid, "result valid after reset")

  logic unused_in_valid;
  assign unused_in_valid = in_valid;

endmodule

bind sliding_window_max_pool_top swmp_checker u_swmp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_stream.valid),
  .in_ready  (in_stream.ready),
  .out_valid (out_stream.valid),
  .out_ready (out_stream.ready),
  .out_item  (out_stream.data)
);
